FILE: rtl/linear_system_2x2_solver_assert.svh
// assertion macros for the 2x2 linear system solver
`ifndef LINEAR_SYSTEM_2X2_SOLVER_ASSERT_SVH
`define LINEAR_SYSTEM_2X2_SOLVER_ASSERT_SVH

// same-cycle implication
`define LSS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lss_pkg.sv
// shared types and constants of the 2x2 linear system solver
package lss_pkg;

  localparam int CoefW    = 16;
  localparam int SolW     = 48;
  localparam int InDataW  = 6 * CoefW;
  localparam int OutDataW = 104;
  localparam int FracBitsDefault = 16;

  typedef enum logic [1:0] {
    ST_UNIQUE = 2'd0,
    ST_INF    = 2'd1,
    ST_NONE   = 2'd2
  } status_t;

endpackage

FILE: rtl/linear_system_2x2_solver.sv
// 2x2 linear system solver: pipelined classification and fixed-point solve
//
// channel  | dir | handshake                  | payload
// ---------+-----+----------------------------+----------------------------------
// s_axis   | in  | s_axis_tvalid/s_axis_tready | coef_a..coef_r, 16 bits each
// m_axis   | out | m_axis_tvalid/m_axis_tready | status, sol_x, sol_y
//
// one transaction per cycle sustained while m_axis does not stall
// the two restoring dividers produce one quotient bit per stage
// rst is synchronous; it clears only the valid bits of every stage
// a stall on m_axis freezes the whole pipeline; s_axis_tready drops with it
`include "linear_system_2x2_solver_assert.svh"

module linear_system_2x2_solver #(
  parameter int FRAC_BITS = lss_pkg::FracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // coef_a, coef_b, coef_c, coef_p, coef_q, coef_r from bit 0 up
  input  logic [lss_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[1:0], sol_x[49:2], sol_y[97:50], zero pad above
  output logic [lss_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lss_pkg::*;

  // dividend is |numerator| (up to 2^31) shifted by the fraction bits
  localparam int DivW = 32 + FRAC_BITS;

  // pipeline advances as a whole whenever the output register can take data
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: the six cross products and zero flags
  logic               s1_valid;
  logic signed [31:0] pr_aq, pr_pb, pr_ar, pr_pc, pr_cq, pr_br;
  logic               s1_a_zero, s1_b_zero, s1_c_zero, s1_p_zero;

  logic signed [CoefW-1:0] in_a, in_b, in_c, in_p, in_q, in_r;
  assign in_a = s_axis_tdata[0*CoefW +: CoefW];
  assign in_b = s_axis_tdata[1*CoefW +: CoefW];
  assign in_c = s_axis_tdata[2*CoefW +: CoefW];
  assign in_p = s_axis_tdata[3*CoefW +: CoefW];
  assign in_q = s_axis_tdata[4*CoefW +: CoefW];
  assign in_r = s_axis_tdata[5*CoefW +: CoefW];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
    end
    if (adv) begin
      pr_aq     <= in_a * in_q;
      pr_pb     <= in_p * in_b;
      pr_ar     <= in_a * in_r;
      pr_pc     <= in_p * in_c;
      pr_cq     <= in_c * in_q;
      pr_br     <= in_b * in_r;
      s1_a_zero <= (in_a == '0);
      s1_b_zero <= (in_b == '0);
      s1_c_zero <= (in_c == '0);
      s1_p_zero <= (in_p == '0);
    end
  end

  // stage 2: determinant, numerators, status, magnitudes and signs
  logic signed [32:0] det, num_x, num_y;
  status_t            st_comb;
  assign det   = 33'(pr_aq) - 33'(pr_pb);
  assign num_x = 33'(pr_cq) - 33'(pr_br);
  assign num_y = 33'(pr_ar) - 33'(pr_pc);

  always_comb begin
    if (!s1_a_zero) begin
      if (det == '0) begin
        st_comb = (num_y == '0) ? ST_INF : ST_NONE;
      end else begin
        st_comb = ST_UNIQUE;
      end
    end else if (s1_b_zero) begin
      st_comb = s1_c_zero ? ST_INF : ST_NONE;
    end else if (s1_p_zero) begin
      // b*r - q*c is the negated x numerator
      st_comb = (num_x == '0) ? ST_INF : ST_NONE;
    end else begin
      st_comb = ST_UNIQUE;
    end
  end

  logic [31:0] xmag, ymag;
  assign xmag = num_x[32] ? 32'(-num_x) : 32'(num_x);
  assign ymag = num_y[32] ? 32'(-num_y) : 32'(num_y);

  // divider stages: index 0 is the stage 2 register, index DivW is the last
  logic          dv_valid  [0:DivW];
  status_t       dv_status [0:DivW];
  logic [31:0]   dv_d      [0:DivW];
  logic [31:0]   dv_xrem   [0:DivW];
  logic [31:0]   dv_yrem   [0:DivW];
  logic [DivW-1:0] dv_xdq  [0:DivW];
  logic [DivW-1:0] dv_ydq  [0:DivW];
  logic          dv_xneg   [0:DivW];
  logic          dv_yneg   [0:DivW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s1_valid;
    end
    if (adv) begin
      dv_status[0] <= st_comb;
      dv_d[0]      <= det[32] ? 32'(-det) : 32'(det);
      dv_xrem[0]   <= '0;
      dv_yrem[0]   <= '0;
      dv_xdq[0]    <= DivW'(xmag) << FRAC_BITS;
      dv_ydq[0]    <= DivW'(ymag) << FRAC_BITS;
      dv_xneg[0]   <= num_x[32] ^ det[32];
      dv_yneg[0]   <= num_y[32] ^ det[32];
    end
  end

  for (genvar k = 0; k < DivW; k++) begin : g_div
    logic [32:0] x_trial, y_trial;
    logic        x_ge, y_ge;
    // shift one dividend bit into the partial remainder
    assign x_trial = {dv_xrem[k], dv_xdq[k][DivW-1]};
    assign y_trial = {dv_yrem[k], dv_ydq[k][DivW-1]};
    assign x_ge    = (x_trial >= {1'b0, dv_d[k]});
    assign y_ge    = (y_trial >= {1'b0, dv_d[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
      if (adv) begin
        dv_status[k+1] <= dv_status[k];
        dv_d[k+1]      <= dv_d[k];
        dv_xneg[k+1]   <= dv_xneg[k];
        dv_yneg[k+1]   <= dv_yneg[k];
        dv_xrem[k+1]   <= x_ge ? 32'(x_trial - {1'b0, dv_d[k]}) : x_trial[31:0];
        dv_yrem[k+1]   <= y_ge ? 32'(y_trial - {1'b0, dv_d[k]}) : y_trial[31:0];
        // quotient bits fill in from the bottom as dividend bits leave the top
        dv_xdq[k+1]    <= {dv_xdq[k][DivW-2:0], x_ge};
        dv_ydq[k+1]    <= {dv_ydq[k][DivW-2:0], y_ge};
      end
    end
  end

  // output register: apply signs, zero the solution unless unique
  logic [SolW-1:0] qx, qy, sol_x, sol_y;
  logic            uniq;
  assign uniq = (dv_status[DivW] == ST_UNIQUE);
  assign qx   = SolW'(dv_xdq[DivW]);
  assign qy   = SolW'(dv_ydq[DivW]);
  assign sol_x = !uniq ? '0 : (dv_xneg[DivW] ? -qx : qx);
  assign sol_y = !uniq ? '0 : (dv_yneg[DivW] ? -qy : qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= dv_valid[DivW];
    end
    if (adv) begin
      m_axis_tdata <= {6'd0, sol_y, sol_x, dv_status[DivW]};
    end
  end

  `LSS_ASSERT_NOW(a_ready_follows_out, clk, rst, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")
  `LSS_ASSERT_NOW(a_zero_unless_unique, clk, rst, m_axis_tvalid && (m_axis_tdata[1:0] != ST_UNIQUE), m_axis_tdata[97:2] == '0, "nonzero solution on a non-unique result")
  `LSS_ASSERT_NEXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, s1_valid, "accepted transaction missing from first stage")

endmodule
